// ----- sv/hrd_pkg.sv -----
// Shared constants and codes for the hybrid race detector.
// No dependencies; compiled first.
package hrd_pkg;

    localparam int CMD_W    = 3;
    localparam int THREAD_W = 3;
    localparam int LOCK_W   = 4;
    localparam int VAR_W    = 10;
    localparam int INSTR_W  = 32;
    localparam int KIND_W   = 2;

    localparam int DEF_THREADS    = 8;
    localparam int DEF_LOCKS      = 16;
    localparam int DEF_VARIABLES  = 1024;
    localparam int DEF_CLOCK_BITS = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_CREATE  = 3'd0,
        CMD_JOIN    = 3'd1,
        CMD_ACQUIRE = 3'd2,
        CMD_RELEASE = 3'd3,
        CMD_READ    = 3'd4,
        CMD_WRITE   = 3'd5,
        CMD_CALL    = 3'd6
    } cmd_t;

    typedef enum logic [KIND_W-1:0] {
        RACE_WR = 2'd0,
        RACE_WW = 2'd1,
        RACE_RW = 2'd2
    } kind_t;

endpackage

// ----- sv/hrd_ifs.sv -----
// Valid/ready channel interfaces for thread events and race records.
// Depends on hrd_pkg for field widths.
interface hrd_ev_if;
    logic                             valid;
    logic                             ready;
    logic [hrd_pkg::CMD_W-1:0]        command;
    logic [hrd_pkg::THREAD_W-1:0]     thread_id;
    logic [hrd_pkg::THREAD_W-1:0]     other_thread;
    logic [hrd_pkg::LOCK_W-1:0]       lock_id;
    logic [hrd_pkg::VAR_W-1:0]        var_id;
    logic                             on_stack;
    logic [hrd_pkg::INSTR_W-1:0]      instruction_id;

    modport source (
        output valid, command, thread_id, other_thread, lock_id, var_id, on_stack,
               instruction_id,
        input  ready
    );
    modport sink (
        input  valid, command, thread_id, other_thread, lock_id, var_id, on_stack,
               instruction_id,
        output ready
    );
endinterface

interface hrd_race_if;
    logic                             valid;
    logic                             ready;
    logic [hrd_pkg::KIND_W-1:0]       race_kind;
    logic [hrd_pkg::INSTR_W-1:0]      first_instruction;
    logic [hrd_pkg::INSTR_W-1:0]      second_instruction;
    logic [hrd_pkg::VAR_W-1:0]        race_var;
    logic                             last_race;

    modport source (
        output valid, race_kind, first_instruction, second_instruction, race_var,
               last_race,
        input  ready
    );
    modport sink (
        input  valid, race_kind, first_instruction, second_instruction, race_var,
               last_race,
        output ready
    );
endinterface

// ----- sv/hybrid_race_detector_unit.sv -----
// Hybrid race detector: vector clocks with epochs plus locksets.
// Acquire, no-op and stack access finish in idle; release bumps the thread's own clock;
// create/join merge clocks per thread, then bump the source's; a write also checks and clears
// every read entry; a read or write that hits the current epoch ends early. Race records cost
// extra cycles only while the output is stalled. One event at a time, set by the single write
// port of the thread clock and read-entry memories. Reset: control clears at once, then a pass
// zeroes the memories (thread 0's own clock starts at 1) while ready stays low.
module hybrid_race_detector_unit #(
    parameter int THREADS    = hrd_pkg::DEF_THREADS,
    parameter int LOCKS      = hrd_pkg::DEF_LOCKS,
    parameter int VARIABLES  = hrd_pkg::DEF_VARIABLES,
    parameter int CLOCK_BITS = hrd_pkg::DEF_CLOCK_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    hrd_ev_if.sink      ev,
    hrd_race_if.source  race
);

    localparam int TW      = $clog2(THREADS);
    localparam int VW      = $clog2(VARIABLES);
    localparam int RAW     = VW + TW;
    localparam int TAW     = 2 * TW;
    localparam int RDEPTH  = 2 ** RAW;
    localparam int WDEPTH  = 2 ** VW;
    localparam int TDEPTH  = 2 ** TAW;
    localparam int CLR_LEN = (RDEPTH > TDEPTH) ? RDEPTH : TDEPTH;
    localparam int CLRW    = $clog2(CLR_LEN);
    localparam int IW      = hrd_pkg::INSTR_W;

    localparam logic [TW-1:0]         LAST_T  = TW'(THREADS - 1);
    localparam logic [CLOCK_BITS-1:0] CLK_MAX = '1;

    typedef struct packed {
        logic [CLOCK_BITS-1:0] clk;
        logic [LOCKS-1:0]      ls;
        logic [IW-1:0]         instr;
    } rd_ent_t;

    typedef struct packed {
        logic [TW-1:0]         thread;
        logic [CLOCK_BITS-1:0] clk;
        logic [LOCKS-1:0]      ls;
        logic [IW-1:0]         instr;
    } wr_ent_t;

    typedef enum logic [11:0] {
        S_CLEAR   = 12'b0000_0000_0001,
        S_IDLE    = 12'b0000_0000_0010,
        S_MRG_RD  = 12'b0000_0000_0100,
        S_MRG_WR  = 12'b0000_0000_1000,
        S_BUMP_RD = 12'b0000_0001_0000,
        S_BUMP_WR = 12'b0000_0010_0000,
        S_ACC_RD  = 12'b0000_0100_0000,
        S_ACC_EP  = 12'b0000_1000_0000,
        S_ACC_CHK = 12'b0001_0000_0000,
        S_WLP_RD  = 12'b0010_0000_0000,
        S_WLP_EV  = 12'b0100_0000_0000,
        S_FLUSH   = 12'b1000_0000_0000
    } state_t;

    // memories
    logic [CLOCK_BITS-1:0] tclk_mem [TDEPTH];
    rd_ent_t               rmem     [RDEPTH];
    wr_ent_t               wmem     [WDEPTH];

    logic                  tc_we, tca_re, tcb_re;
    logic [TAW-1:0]        tc_wa, tca_a, tcb_a;
    logic [CLOCK_BITS-1:0] tc_wd, tca_q, tcb_q;
    logic                  rm_we, rm_re;
    logic [RAW-1:0]        rm_wa, rm_ra;
    rd_ent_t               rm_wd, rm_q;
    logic                  wm_we, wm_re;
    logic [VW-1:0]         wm_wa, wm_ra;
    wr_ent_t               wm_wd, wm_q;

    always_ff @(posedge clk)
    begin
        if (tc_we)
            tclk_mem[tc_wa] <= tc_wd;
        if (tca_re)
            tca_q <= tclk_mem[tca_a];
        if (tcb_re)
            tcb_q <= tclk_mem[tcb_a];
        if (rm_we)
            rmem[rm_wa] <= rm_wd;
        if (rm_re)
            rm_q <= rmem[rm_ra];
        if (wm_we)
            wmem[wm_wa] <= wm_wd;
        if (wm_re)
            wm_q <= wmem[wm_ra];
    end

    // control and per-thread state
    state_t                state_reg, state_next;
    logic [CLRW-1:0]       clr_reg, clr_next;
    logic [TW-1:0]         idx_reg, idx_next;
    logic [THREADS-1:0]    known_reg, known_next;
    logic [LOCKS-1:0]      lockset_reg [THREADS];
    logic [LOCKS-1:0]      lockset_next [THREADS];
    logic                  pend_valid_reg, pend_valid_next;
    logic                  race_valid_reg, race_valid_next;

    // payload
    logic [TW-1:0]         t_reg, t_next, d_reg, d_next, s_reg, s_next, x_reg, x_next;
    logic                  fresh_reg, fresh_next, wr_reg, wr_next;
    logic [VW-1:0]         v_reg, v_next;
    logic [IW-1:0]         instr_reg, instr_next;
    logic [LOCKS-1:0]      ls_reg, ls_next;
    logic [CLOCK_BITS-1:0] c_reg, c_next;
    hrd_pkg::kind_t        pend_kind_reg, pend_kind_next;
    logic [IW-1:0]         pend_first_reg, pend_first_next;
    hrd_pkg::kind_t        race_kind_reg, race_kind_next;
    logic [IW-1:0]         race_first_reg, race_first_next;
    logic [IW-1:0]         race_second_reg, race_second_next;
    logic [VW-1:0]         race_var_reg, race_var_next;
    logic                  race_last_reg, race_last_next;

    // scratch
    logic                  can_push, push, push_last;
    logic                  t_ok, u_ok, l_ok, v_ok;
    logic [TW-1:0]         ev_t, ev_u;
    logic [LOCKS-1:0]      lbit, nls;
    logic [CLOCK_BITS-1:0] dval;
    logic                  same_w, older, hit;
    hrd_pkg::cmd_t         cmd;

    assign can_push = !race_valid_reg || race.ready;
    assign cmd      = hrd_pkg::cmd_t'(ev.command);
    assign ev_t     = TW'(ev.thread_id);
    assign ev_u     = TW'(ev.other_thread);
    assign t_ok     = 32'(ev.thread_id) < THREADS;
    assign u_ok     = 32'(ev.other_thread) < THREADS;
    assign l_ok     = 32'(ev.lock_id) < LOCKS;
    assign v_ok     = 32'(ev.var_id) < VARIABLES;
    assign lbit     = LOCKS'(1) << ev.lock_id;

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        idx_next        = idx_reg;
        known_next      = known_reg;
        lockset_next    = lockset_reg;
        pend_valid_next = pend_valid_reg;
        t_next          = t_reg;
        d_next          = d_reg;
        s_next          = s_reg;
        x_next          = x_reg;
        fresh_next      = fresh_reg;
        wr_next         = wr_reg;
        v_next          = v_reg;
        instr_next      = instr_reg;
        ls_next         = ls_reg;
        c_next          = c_reg;
        pend_kind_next  = pend_kind_reg;
        pend_first_next = pend_first_reg;
        push            = 1'b0;
        push_last       = 1'b0;
        tc_we  = 1'b0;  tc_wa = '0;  tc_wd = '0;
        tca_re = 1'b0;  tca_a = '0;
        tcb_re = 1'b0;  tcb_a = '0;
        rm_we  = 1'b0;  rm_wa = '0;  rm_wd = '0;
        rm_re  = 1'b0;  rm_ra = '0;
        wm_we  = 1'b0;  wm_wa = '0;  wm_wd = '0;
        wm_re  = 1'b0;  wm_ra = '0;
        dval   = '0;
        nls    = '0;
        same_w = 1'b0;
        older  = 1'b0;
        hit    = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                if ({1'b0, clr_reg} < (CLRW+1)'(RDEPTH))
                begin
                    rm_we = 1'b1;
                    rm_wa = clr_reg[RAW-1:0];
                    wm_we = 1'b1;
                    wm_wa = clr_reg[RAW-1:TW];
                end
                if ({1'b0, clr_reg} < (CLRW+1)'(TDEPTH))
                begin
                    tc_we = 1'b1;
                    tc_wa = clr_reg[TAW-1:0];
                    // thread 0 starts at clock 1
                    tc_wd = (clr_reg == '0) ? CLOCK_BITS'(1) : '0;
                end
                clr_next = clr_reg + 1'b1;
                if (clr_reg == CLRW'(CLR_LEN - 1))
                    state_next = S_IDLE;
            end

            S_IDLE:
            begin
                if (ev.valid)
                begin
                    case (cmd)
                        hrd_pkg::CMD_CREATE:
                        begin
                            if (t_ok && u_ok)
                            begin
                                fresh_next         = !known_reg[ev_u];
                                known_next[ev_u]   = 1'b1;
                                known_next[ev_t]   = 1'b1;
                                lockset_next[ev_u] = lockset_reg[ev_t];
                                d_next     = ev_u;
                                s_next     = ev_t;
                                x_next     = ev_t;
                                idx_next   = '0;
                                state_next = S_MRG_RD;
                            end
                        end
                        hrd_pkg::CMD_JOIN:
                        begin
                            if (t_ok && u_ok)
                            begin
                                fresh_next       = 1'b0;
                                known_next[ev_u] = 1'b1;
                                known_next[ev_t] = 1'b1;
                                d_next     = ev_t;
                                s_next     = ev_u;
                                x_next     = ev_u;
                                idx_next   = '0;
                                state_next = S_MRG_RD;
                            end
                        end
                        hrd_pkg::CMD_ACQUIRE:
                        begin
                            if (t_ok && l_ok)
                                lockset_next[ev_t] = lockset_reg[ev_t] | lbit;
                        end
                        hrd_pkg::CMD_RELEASE:
                        begin
                            if (t_ok && l_ok)
                            begin
                                lockset_next[ev_t] = lockset_reg[ev_t] & ~lbit;
                                known_next[ev_t]   = 1'b1;
                                x_next     = ev_t;
                                state_next = S_BUMP_RD;
                            end
                        end
                        hrd_pkg::CMD_READ, hrd_pkg::CMD_WRITE:
                        begin
                            if (t_ok && v_ok)
                            begin
                                known_next[ev_t] = 1'b1;
                                if (!ev.on_stack)
                                begin
                                    t_next     = ev_t;
                                    v_next     = VW'(ev.var_id);
                                    instr_next = ev.instruction_id;
                                    ls_next    = lockset_reg[ev_t];
                                    wr_next    = (cmd == hrd_pkg::CMD_WRITE);
                                    state_next = S_ACC_RD;
                                end
                            end
                        end
                        hrd_pkg::CMD_CALL:
                        begin
                            state_next = S_IDLE;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_MRG_RD:
            begin
                tca_re     = 1'b1;
                tca_a      = {d_reg, idx_reg};
                tcb_re     = 1'b1;
                tcb_a      = {s_reg, idx_reg};
                state_next = S_MRG_WR;
            end

            S_MRG_WR:
            begin
                // a child created before it was known starts from a fresh clock
                if (fresh_reg)
                    dval = (idx_reg == d_reg) ? CLOCK_BITS'(1) : '0;
                else
                    dval = tca_q;
                tc_we = 1'b1;
                tc_wa = {d_reg, idx_reg};
                tc_wd = (tcb_q > dval) ? tcb_q : dval;
                if (idx_reg == LAST_T)
                    state_next = S_BUMP_RD;
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_MRG_RD;
                end
            end

            S_BUMP_RD:
            begin
                tca_re     = 1'b1;
                tca_a      = {x_reg, x_reg};
                state_next = S_BUMP_WR;
            end

            S_BUMP_WR:
            begin
                tc_we      = 1'b1;
                tc_wa      = {x_reg, x_reg};
                tc_wd      = (tca_q == CLK_MAX) ? tca_q : tca_q + 1'b1;
                state_next = S_IDLE;
            end

            S_ACC_RD:
            begin
                wm_re      = 1'b1;
                wm_ra      = v_reg;
                rm_re      = 1'b1;
                rm_ra      = {v_reg, t_reg};
                tca_re     = 1'b1;
                tca_a      = {t_reg, t_reg};
                state_next = S_ACC_EP;
            end

            S_ACC_EP:
            begin
                c_next     = tca_q;
                tcb_re     = 1'b1;
                tcb_a      = {t_reg, wm_q.thread};
                state_next = S_ACC_CHK;
            end

            S_ACC_CHK:
            begin
                same_w = (c_reg != '0) && (wm_q.clk == c_reg) && (wm_q.thread == t_reg);
                older  = wm_q.clk > tcb_q;
                if (!wr_reg)
                begin
                    if (((c_reg != '0) && (rm_q.clk == c_reg)) || same_w)
                        state_next = S_IDLE;
                    else
                    begin
                        rm_we = 1'b1;
                        rm_wa = {v_reg, t_reg};
                        rm_wd = '{clk: c_reg, ls: ls_reg, instr: instr_reg};
                        if (older && ((ls_reg & wm_q.ls) == '0))
                        begin
                            pend_valid_next = 1'b1;
                            pend_kind_next  = hrd_pkg::RACE_WR;
                            pend_first_next = wm_q.instr;
                        end
                        state_next = S_FLUSH;
                    end
                end
                else
                begin
                    if (same_w)
                        state_next = S_IDLE;
                    else
                    begin
                        nls = older ? (wm_q.ls & ls_reg) : ls_reg;
                        if (older && (nls == '0))
                        begin
                            pend_valid_next = 1'b1;
                            pend_kind_next  = hrd_pkg::RACE_WW;
                            pend_first_next = wm_q.instr;
                        end
                        wm_we      = 1'b1;
                        wm_wa      = v_reg;
                        wm_wd      = '{thread: t_reg, clk: c_reg, ls: nls, instr: instr_reg};
                        idx_next   = '0;
                        state_next = S_WLP_RD;
                    end
                end
            end

            S_WLP_RD:
            begin
                rm_re      = 1'b1;
                rm_ra      = {v_reg, idx_reg};
                tca_re     = 1'b1;
                tca_a      = {t_reg, idx_reg};
                state_next = S_WLP_EV;
            end

            S_WLP_EV:
            begin
                hit = (rm_q.clk != '0) && (rm_q.clk > tca_q) && ((rm_q.ls & ls_reg) == '0);
                // a new record needs the pending one out of the way first
                if (!(hit && pend_valid_reg && !can_push))
                begin
                    rm_we = 1'b1;
                    rm_wa = {v_reg, idx_reg};
                    rm_wd = '{clk: '0, ls: rm_q.ls, instr: rm_q.instr};
                    if (hit)
                    begin
                        push            = pend_valid_reg;
                        pend_valid_next = 1'b1;
                        pend_kind_next  = hrd_pkg::RACE_RW;
                        pend_first_next = rm_q.instr;
                    end
                    if (idx_reg == LAST_T)
                        state_next = S_FLUSH;
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_WLP_RD;
                    end
                end
            end

            S_FLUSH:
            begin
                if (!pend_valid_reg)
                    state_next = S_IDLE;
                else if (can_push)
                begin
                    push            = 1'b1;
                    push_last       = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register, loaded from the pending record
    always_comb
    begin
        race_valid_next  = race_valid_reg;
        race_kind_next   = race_kind_reg;
        race_first_next  = race_first_reg;
        race_second_next = race_second_reg;
        race_var_next    = race_var_reg;
        race_last_next   = race_last_reg;
        if (push)
        begin
            race_valid_next  = 1'b1;
            race_kind_next   = pend_kind_reg;
            race_first_next  = pend_first_reg;
            race_second_next = instr_reg;
            race_var_next    = v_reg;
            race_last_next   = push_last;
        end
        else if (race.ready)
            race_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            idx_reg        <= '0;
            known_reg      <= THREADS'(1);
            pend_valid_reg <= 1'b0;
            race_valid_reg <= 1'b0;
            for (int i = 0; i < THREADS; i++)
                lockset_reg[i] <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            idx_reg        <= idx_next;
            known_reg      <= known_next;
            pend_valid_reg <= pend_valid_next;
            race_valid_reg <= race_valid_next;
            lockset_reg    <= lockset_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg           <= t_next;
        d_reg           <= d_next;
        s_reg           <= s_next;
        x_reg           <= x_next;
        fresh_reg       <= fresh_next;
        wr_reg          <= wr_next;
        v_reg           <= v_next;
        instr_reg       <= instr_next;
        ls_reg          <= ls_next;
        c_reg           <= c_next;
        pend_kind_reg   <= pend_kind_next;
        pend_first_reg  <= pend_first_next;
        race_kind_reg   <= race_kind_next;
        race_first_reg  <= race_first_next;
        race_second_reg <= race_second_next;
        race_var_reg    <= race_var_next;
        race_last_reg   <= race_last_next;
    end

    assign ev.ready                = (state_reg == S_IDLE);
    assign race.valid              = race_valid_reg;
    assign race.race_kind          = race_kind_reg;
    assign race.first_instruction  = race_first_reg;
    assign race.second_instruction = race_second_reg;
    assign race.race_var           = hrd_pkg::VAR_W'(race_var_reg);
    assign race.last_race          = race_last_reg;

endmodule
